/* rtl/core/max_note_polyphony_unit_defines.svh */
// Assertion macros for the polyphony unit.
// Each macro checks a property on the rising edge of clock, with reset masking it.
`ifndef MAX_NOTE_POLYPHONY_UNIT_DEFINES_SVH
`define MAX_NOTE_POLYPHONY_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNP_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MNP_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/core/mnp_pkg.sv */
package mnp_pkg;

   // Field widths of the note and result transactions.
   localparam int START_W  = 16;
   localparam int LENGTH_W = 16;
   localparam int STOP_W   = 17;
   localparam int POLY_W   = 9;

   // Minimum note length after reset, in ticks.
   localparam logic [LENGTH_W-1:0] MIN_LENGTH_RESET = 16'd10;
   // Largest count that the result field can carry.
   localparam logic [POLY_W-1:0]   POLY_LIMIT       = 9'd511;

   // One stored note: its first tick and the first tick after it.
   typedef struct packed {
      logic [STOP_W-1:0]  stop_tick;
      logic [START_W-1:0] start_tick;
   } note_entry_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_OUTER,
      ST_INNER,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/max_note_polyphony_unit.sv */
// Notes are accepted one per cycle while loading; a transaction with tlast starts the sweep.
// The sweep walks every pair of stored notes, one compare per cycle in the inner state, through the
// single compare unit on the two read ports of the note memory, and then posts the peak.
// The result is posted once the sweep is done and the output is free.
// Reset is synchronous: it empties the set, clears the output valid and sets min_length to 10.
// The note memory is not cleared; only entries written in the current set are read.
module max_note_polyphony_unit
   import mnp_pkg::*;
#(
   parameter int MAX_NOTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: min_length.
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   // Note transactions.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] note_start, [31:16] note_length
   input  logic        req_tlast,    // last_note
   // Result transactions.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [8:0] max_polyphony, [15:9] zero
);

   localparam int AW = $clog2(MAX_NOTES);
   localparam int CW = $clog2(MAX_NOTES + 1);
   localparam int BW = (CW > POLY_W) ? CW : POLY_W;

   // Registers.
   state_type             state_ff, state_in;
   logic [LENGTH_W-1:0]   min_length_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         j_ff, j_in;
   logic [AW-1:0]         i_ff, i_in;
   logic [CW-1:0]         acc_ff, acc_in;
   logic [CW-1:0]         best_ff, best_in;
   logic                  cmp_valid_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POLY_W-1:0]     rsp_data_ff, rsp_data_in;
   note_entry_type        rd_a_ff, rd_b_ff;
   note_entry_type        note_mem [MAX_NOTES];

   // Control and datapath signals.
   logic                  req_fire;
   logic                  mem_we;
   note_entry_type        wr_entry;
   logic [START_W-1:0]    in_start;
   logic [LENGTH_W-1:0]   in_length;
   logic [LENGTH_W-1:0]   eff_length;
   logic [AW-1:0]         last_idx;
   logic                  hit;
   logic [CW-1:0]         total;
   logic                  out_free;
   logic [BW-1:0]         best_wide;

   assign in_start   = req_tdata[START_W-1:0];
   assign in_length  = req_tdata[START_W+LENGTH_W-1:START_W];
   assign eff_length = (in_length < min_length_ff) ? min_length_ff : in_length;
   assign wr_entry.start_tick = in_start;
   assign wr_entry.stop_tick  = STOP_W'(in_start) + STOP_W'(eff_length);

   assign req_fire = req_tvalid && req_tready;
   assign last_idx = AW'(count_ff - CW'(1));
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Shared compare unit: does note i sound at the start of note j?
   assign hit = (rd_b_ff.start_tick <= rd_a_ff.start_tick) &&
                (STOP_W'(rd_a_ff.start_tick) < rd_b_ff.stop_tick);
   assign total = acc_ff + CW'(hit);

   // Result saturates at the field limit.
   assign best_wide = BW'(best_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_tlast) begin
               state_in = ST_OUTER;
            end
         end
         ST_OUTER: begin
            state_in = ST_INNER;
         end
         ST_INNER: begin
            if (i_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (j_ff == last_idx) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_OUTER;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Sequencer outputs and datapath next values.
   always_comb begin
      req_tready   = 1'b0;
      mem_we       = 1'b0;
      count_in     = count_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmp_valid_ff && hit) begin
         acc_in = acc_ff + CW'(1);
      end
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_fire) begin
               if (count_ff < CW'(MAX_NOTES)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               j_in    = '0;
               best_in = '0;
            end
         end
         ST_OUTER: begin
            i_in   = '0;
            acc_in = '0;
         end
         ST_INNER: begin
            i_in = i_ff + AW'(1);
         end
         ST_DRAIN: begin
            if (total > best_ff) begin
               best_in = total;
            end
            j_in = j_ff + AW'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (best_wide > BW'(POLY_LIMIT)) ? POLY_LIMIT
                                                             : best_wide[POLY_W-1:0];
               count_in     = '0;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         min_length_ff <= MIN_LENGTH_RESET;
         count_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cmp_valid_ff  <= (state_ff == ST_INNER);
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            min_length_ff <= csr_wdata;
         end
      end
   end

   // Sweep counters and result payload.
   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      i_ff        <= i_in;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Note memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[count_ff[AW-1:0]] <= wr_entry;
      end
      rd_a_ff <= note_mem[j_ff];
      rd_b_ff <= note_mem[i_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-POLY_W){1'b0}}, rsp_data_ff};

   // Assertions.
   `include "max_note_polyphony_unit_defines.svh"

   `MNP_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(MAX_NOTES), "note count above depth")
   `MNP_ASSERT_NOW(a_best_bound, state_ff != ST_LOAD, best_ff <= count_ff, "peak above count")
   `MNP_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == ST_DONE),
      "result posted outside the final state")
   `MNP_ASSERT_NEXT(a_walk_after_last, req_fire && req_tlast, state_ff == ST_OUTER,
      "sweep did not start after the last note")

endmodule

/* verif/max_note_polyphony_unit_tb.sv */
`timescale 1ns / 100ps

module max_note_polyphony_unit_tb;
   import mnp_pkg::*;

   localparam int NOTE_CAP   = 256;
   localparam int LONG_HOLD  = 3000;
   localparam int IDLE_LIMIT = 400000;
   localparam int ITEM_GOAL  = 700;

   // Predicts the peak polyphony of each note set and checks the results against it.
   class poly_scoreboard;
      logic [START_W-1:0]  start_mem [NOTE_CAP];
      logic [STOP_W-1:0]   stop_mem [NOTE_CAP];
      int unsigned         held;
      logic [LENGTH_W-1:0] min_len;
      logic [POLY_W-1:0]   peak_queue [$];
      int                  fails;

      function new();
         held    = 0;
         min_len = MIN_LENGTH_RESET;
         fails   = 0;
      endfunction

      task report(input string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         fails++;
      endtask

      function void set_min_length(input logic [LENGTH_W-1:0] value);
         min_len = value;
      endfunction

      function int pending();
         return peak_queue.size();
      endfunction

      // The sounding count only rises at a note start, so the peak lies at one of them.
      function logic [POLY_W-1:0] peak_count();
         int best;
         int sounding;
         best = 0;
         for (int j = 0; j < held; j++) begin
            sounding = 0;
            for (int i = 0; i < held; i++) begin
               if ({1'b0, start_mem[i]} <= {1'b0, start_mem[j]} &&
                   {1'b0, start_mem[j]} < stop_mem[i])
                  sounding++;
            end
            if (sounding > best)
               best = sounding;
         end
         if (best > int'(POLY_LIMIT))
            best = int'(POLY_LIMIT);
         return best[POLY_W-1:0];
      endfunction

      // Stores an accepted note; a note beyond the store's capacity is dropped.
      function void note_input(input logic [START_W-1:0] start_t,
                               input logic [LENGTH_W-1:0] len_t, input bit last);
         logic [LENGTH_W-1:0] len_eff;
         len_eff = (len_t < min_len) ? min_len : len_t;
         if (held < NOTE_CAP) begin
            start_mem[held] = start_t;
            stop_mem[held]  = {1'b0, start_t} + {1'b0, len_eff};
            held++;
         end
         if (last) begin
            peak_queue = {peak_queue, peak_count()};
            held = 0;
         end
      endfunction

      task check_result(input logic [15:0] data);
         logic [POLY_W-1:0] want;
         if (peak_queue.size() == 0) begin
            report($sformatf("unexpected result 0x%04h", data));
         end else begin
            want = peak_queue.pop_front();
            if (data[POLY_W-1:0] !== want)
               report($sformatf("max_polyphony %0d, expected %0d", data[POLY_W-1:0], want));
            if (data[15:POLY_W] !== '0)
               report($sformatf("padding bits 0x%02h not zero", data[15:POLY_W]));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [15:0] note_start, [31:16] note_length
   logic        req_tlast = 1'b0;  // last_note
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [8:0] max_polyphony, [15:9] zero

   poly_scoreboard sb = new();
   bit calm = 1'b0;
   bit long_hold_req = 1'b0;
   bit hold_done = 1'b0;
   int notes_sent = 0;
   int idle_cycles = 0;

   max_note_polyphony_unit #(
      .MAX_NOTES(NOTE_CAP)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(input bit allow_zero);
      int r;
      r = $urandom_range(0, 99);
      if (allow_zero && r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_set_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 6);
      if (r < 95)
         return $urandom_range(7, 24);
      return $urandom_range(25, 64);
   endfunction

   // Offers one note and holds it until the block takes it.
   task automatic send_note(input logic [15:0] start_t, input logic [15:0] len_t,
                            input bit last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {len_t, start_t};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_input(start_t, len_t, last);
      notes_sent++;
      gap = calm ? 0 : pick_gap(1'b1);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Notes cluster inside a window so that they overlap; some lengths hit the extremes.
   task automatic send_random_set(input int count);
      logic [15:0] base;
      logic [15:0] st;
      logic [15:0] ln;
      int span;
      int mode;
      base = 16'($urandom);
      span = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(16, 4000);
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         st = base + 16'($urandom_range(0, span));
         case (mode)
            0: ln = '0;
            1: ln = 16'hFFFF;
            2: ln = 16'($urandom);
            default: ln = 16'($urandom_range(0, 2 * span));
         endcase
         send_note(st, ln, i == count - 1);
      end
   endtask

   // The sender pauses until every result is in and the block has settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_min_length(input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_min_length(value);
   endtask

   // Result receiver: random stalls, plus one long hold on request.
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap(1'b0)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every accepted result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   // Ends the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[max_note_polyphony_unit] ERROR");
         $finish;
      end
   end

   initial begin
      int phase_items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed sets at the reset minimum length: extremes and end-before-start ties.
      send_note(16'd0, 16'd0, 1'b1);
      send_note(16'hFFFF, 16'hFFFF, 1'b1);
      send_note(16'd0, 16'hFFFF, 1'b0);
      send_note(16'hFFFF, 16'hFFFF, 1'b0);
      send_note(16'd100, 16'd5, 1'b1);
      send_note(16'd0, 16'd20, 1'b0);
      send_note(16'd20, 16'd20, 1'b1);
      send_note(16'd300, 16'd40, 1'b0);
      send_note(16'd300, 16'd40, 1'b0);
      send_note(16'd300, 16'd40, 1'b1);

      // Zero-length notes never sound.
      wait_drained();
      write_min_length(16'd0);
      send_note(16'd50, 16'd0, 1'b0);
      send_note(16'd50, 16'd0, 1'b0);
      send_note(16'd50, 16'd5, 1'b1);
      send_note(16'd7, 16'd0, 1'b1);

      // The largest minimum stretches every note to a length of 0xFFFF ticks.
      wait_drained();
      write_min_length(16'hFFFF);
      send_note(16'd0, 16'd0, 1'b0);
      send_note(16'hFFFF, 16'd0, 1'b1);

      // Random phases, each under its own minimum length.
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         case (p)
            0: write_min_length(16'd0);
            1: write_min_length(16'hFFFF);
            2: write_min_length(16'd1);
            7: write_min_length(MIN_LENGTH_RESET);
            default: write_min_length(16'($urandom_range(0, 3000)));
         endcase
         calm = (p == 3);
         if (p == 5)
            long_hold_req = 1'b1;
         if (p == 6)
            send_random_set(NOTE_CAP + 4);
         phase_items = 0;
         while (phase_items < (ITEM_GOAL - NOTE_CAP - 20) / 8) begin
            phase_items -= notes_sent;
            send_random_set(pick_set_size());
            phase_items += notes_sent;
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.fails == 0)
         $display("[max_note_polyphony_unit] OK");
      else
         $display("[max_note_polyphony_unit] ERROR");
      $finish;
   end

endmodule
